### hw/rtl/rfd_pkg.sv
// Package for the response frame deframer: result codes, the result record
// and the CRC-16/CCITT byte update. No dependencies.
`default_nettype none

package rfd_pkg;

  localparam logic [1:0] OK_BYTE = 2'd0;
  localparam logic [1:0] OK_ACCEPT = 2'd1;
  localparam logic [1:0] OK_DROP = 2'd2;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_OPCODE = 3'd1;
  localparam logic [2:0] ERR_TOO_LONG = 3'd2;
  localparam logic [2:0] ERR_CRC = 3'd3;
  localparam logic [2:0] ERR_TIMEOUT = 3'd4;

  localparam logic [2:0] REG_MARKER = 3'd0;
  localparam logic [2:0] REG_MAX_PAYLOAD = 3'd1;
  localparam logic [2:0] REG_TIMEOUT = 3'd2;
  localparam logic [2:0] REG_MAP_0 = 3'd3;
  localparam logic [2:0] REG_MAP_1 = 3'd4;
  localparam logic [2:0] REG_MAP_2 = 3'd5;
  localparam logic [2:0] REG_MAP_3 = 3'd6;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  data_byte;
    logic [7:0]  opcode;
    logic [7:0]  frame_status;
    logic [15:0] frame_len;
    logic [2:0]  error_code;
  } res_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/response_frame_deframer_crc16.sv
// Response frame deframer with CRC-16/CCITT check, top level.
// Depends on rfd_pkg for result codes, the result record and the CRC update.
//
//   Channel   Handshake                 Payload
//   item      item_valid / item_stall   kind, rx_byte
//   result    result_valid / result_stall  out_kind .. error_code
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item is taken per cycle while item stall is low; its result is registered.
// A two-entry output buffer (result register plus skid register) sets the rate.
// Item stall rises only when both entries hold results that have not been taken.
// Reset is synchronous and returns the block to hunting with reset register values.
// Configuration writes are always ready and take effect at once.
`default_nettype none

module response_frame_deframer_crc16 (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic               kind,
  input  wire logic [7:0]         rx_byte,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic [1:0]              out_kind,
  output logic [7:0]              data_byte,
  output logic [7:0]              opcode,
  output logic [7:0]              frame_status,
  output logic [15:0]             frame_len,
  output logic [2:0]              error_code,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);
  import rfd_pkg::*;

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_CRC_LO = 3'd3;
  localparam logic [2:0] PH_CRC_HI = 3'd4;

  logic [7:0]   frame_marker;
  logic [15:0]  max_payload;
  logic [15:0]  timeout_ticks;
  logic [255:0] opcode_map;

  logic [2:0]  phase, phase_next;
  logic [2:0]  hdr_pos, hdr_pos_next;
  logic [7:0]  held_opcode, held_opcode_next;
  logic [7:0]  held_status, held_status_next;
  logic [15:0] held_length, held_length_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;
  logic [15:0] tick_count, tick_count_next;

  res_t result, skid;
  res_t new_res;
  logic new_valid;
  logic skid_full;
  logic accept;
  logic take;
  logic [15:0] crc_upd;
  logic [15:0] tick_inc;
  logic [15:0] length_full;
  logic [15:0] seen_inc;

  assign cfg_ready = 1'b1;
  assign item_stall = skid_full;
  assign accept = item_valid && !item_stall;
  assign take = result_valid && !result_stall;

  assign out_kind = result.out_kind;
  assign data_byte = result.data_byte;
  assign opcode = result.opcode;
  assign frame_status = result.frame_status;
  assign frame_len = result.frame_len;
  assign error_code = result.error_code;

  assign crc_upd = crc_byte(running_crc, rx_byte);
  assign tick_inc = (tick_count != 16'hFFFF) ? tick_count + 16'd1 : tick_count;
  assign length_full = {rx_byte, crc_low_byte};
  assign seen_inc = bytes_seen + 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_marker <= 8'd0;
      max_payload <= 16'd256;
      timeout_ticks <= 16'd10000;
      opcode_map <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MARKER: frame_marker <= cfg_data[7:0];
        REG_MAX_PAYLOAD: max_payload <= cfg_data[15:0];
        REG_TIMEOUT: timeout_ticks <= cfg_data[15:0];
        REG_MAP_0: opcode_map[63:0] <= cfg_data;
        REG_MAP_1: opcode_map[127:64] <= cfg_data;
        REG_MAP_2: opcode_map[191:128] <= cfg_data;
        REG_MAP_3: opcode_map[255:192] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next = phase;
    hdr_pos_next = hdr_pos;
    held_opcode_next = held_opcode;
    held_status_next = held_status;
    held_length_next = held_length;
    bytes_seen_next = bytes_seen;
    running_crc_next = running_crc;
    crc_low_byte_next = crc_low_byte;
    tick_count_next = tick_count;
    new_valid = 1'b0;
    new_res.out_kind = OK_DROP;
    new_res.data_byte = 8'd0;
    new_res.error_code = ERR_NONE;
    if (kind) begin
      if (phase != PH_HUNT) begin
        tick_count_next = tick_inc;
        if (tick_inc >= timeout_ticks) begin
          new_valid = 1'b1;
          new_res.error_code = ERR_TIMEOUT;
          phase_next = PH_HUNT;
          hdr_pos_next = 3'd0;
        end
      end
    end else begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == frame_marker) begin
            phase_next = PH_HEADER;
            hdr_pos_next = 3'd1;
            held_opcode_next = 8'd0;
            held_status_next = 8'd0;
            held_length_next = 16'd0;
            bytes_seen_next = 16'd0;
            crc_low_byte_next = 8'd0;
            tick_count_next = 16'd0;
            running_crc_next = crc_byte(CRC_INIT, rx_byte);
          end
        end
        PH_HEADER: begin
          running_crc_next = crc_upd;
          priority if (hdr_pos == 3'd1) begin
            held_opcode_next = rx_byte;
            hdr_pos_next = 3'd2;
          end else if (hdr_pos == 3'd2) begin
            held_status_next = rx_byte;
            hdr_pos_next = 3'd3;
          end else if (hdr_pos == 3'd3) begin
            crc_low_byte_next = rx_byte;
            hdr_pos_next = 3'd4;
          end else begin
            held_length_next = length_full;
            crc_low_byte_next = 8'd0;
            hdr_pos_next = 3'd0;
            bytes_seen_next = 16'd0;
            if (!opcode_map[held_opcode]) begin
              new_valid = 1'b1;
              new_res.error_code = ERR_OPCODE;
              phase_next = PH_HUNT;
            end else if (length_full > max_payload) begin
              new_valid = 1'b1;
              new_res.error_code = ERR_TOO_LONG;
              phase_next = PH_HUNT;
            end else begin
              phase_next = (length_full == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          running_crc_next = crc_upd;
          bytes_seen_next = seen_inc;
          if (seen_inc >= held_length) begin
            phase_next = PH_CRC_LO;
          end
          new_valid = 1'b1;
          new_res.out_kind = OK_BYTE;
          new_res.data_byte = rx_byte;
        end
        PH_CRC_LO: begin
          crc_low_byte_next = rx_byte;
          phase_next = PH_CRC_HI;
        end
        default: begin
          new_valid = 1'b1;
          phase_next = PH_HUNT;
          hdr_pos_next = 3'd0;
          if ({rx_byte, crc_low_byte} == running_crc) begin
            new_res.out_kind = OK_ACCEPT;
          end else begin
            new_res.error_code = ERR_CRC;
          end
        end
      endcase
    end
    new_res.opcode = held_opcode_next;
    new_res.frame_status = held_status_next;
    new_res.frame_len = held_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      hdr_pos <= 3'd0;
      held_opcode <= 8'd0;
      held_status <= 8'd0;
      held_length <= 16'd0;
      bytes_seen <= 16'd0;
      running_crc <= CRC_INIT;
      crc_low_byte <= 8'd0;
      tick_count <= 16'd0;
    end else if (accept) begin
      phase <= phase_next;
      hdr_pos <= hdr_pos_next;
      held_opcode <= held_opcode_next;
      held_status <= held_status_next;
      held_length <= held_length_next;
      bytes_seen <= bytes_seen_next;
      running_crc <= running_crc_next;
      crc_low_byte <= crc_low_byte_next;
      tick_count <= tick_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (take) begin
        result <= skid;
        skid_full <= 1'b0;
      end
    end else if (accept && new_valid) begin
      if (!result_valid || take) begin
        result <= new_res;
        result_valid <= 1'b1;
      end else begin
        skid <= new_res;
        skid_full <= 1'b1;
      end
    end else if (take) begin
      result_valid <= 1'b0;
    end
  end

  a_skid_needs_result: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> result_valid)
    else $error("skid register full while result register empty");

  a_hdr_pos_in_header: assert property (@(posedge clk) disable iff (rst)
    (hdr_pos != 3'd0) |-> (phase == PH_HEADER))
    else $error("header position set outside the header phase");

  a_tick_in_hunt: assert property (@(posedge clk) disable iff (rst)
    (accept && kind && phase == PH_HUNT) |=> (phase == PH_HUNT))
    else $error("tick while hunting left the hunt phase");

  a_byte_no_error: assert property (@(posedge clk) disable iff (rst)
    (result_valid && out_kind == OK_BYTE) |-> (error_code == ERR_NONE))
    else $error("payload byte item carries an error code");

endmodule

`default_nettype wire
